/* src/spibm_pkg.sv */
// spibm_pkg: shared widths, constants and the result beat type for spi_byte_master
// no dependencies
`default_nettype none

package spibm_pkg;

  localparam int WORD_BITS = 8;
  localparam int BYTE_W    = 8;
  localparam int DIV_W     = 16;
  localparam int BITS_W    = $clog2(WORD_BITS + 1);

  localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(10);
  localparam logic [DIV_W-1:0] DIV_MIN   = DIV_W'(2);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic              sclk;
    logic              mosi;
    logic              cs_n;
    logic [BYTE_W-1:0] rx_byte;
    logic              busy_res;
    logic              done_res;
  } res_t;

endpackage

`default_nettype wire

/* src/spi_byte_master.sv */
// spi_byte_master: mode 0 spi master, one word per transfer, msb first
// depends on spibm_pkg
//
// Every accepted input beat is one system tick of the spi engine and yields exactly one
// result beat, so the block runs at one beat per clock cycle while not stalled; the whole
// tick update (the divider counter increment and its compare against the divider and half
// divider, plus the shift registers) sits between the state registers and the result
// register. Results pass through an output register backed by one skid entry, so input is
// taken every cycle while the result side keeps up and in_stall rises only once the skid
// entry is filled. The divider register is written through the always ready cfg port.
`default_nettype none

module spi_byte_master import spibm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic [DIV_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              in_start_req,
  input  wire logic [BYTE_W-1:0] in_tx_byte,
  input  wire logic              in_miso_bit,
  input  wire logic              in_soft_clear,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic              out_sclk,
  output      logic              out_mosi,
  output      logic              out_cs_n,
  output      logic [BYTE_W-1:0] out_rx_byte,
  output      logic              out_busy_res,
  output      logic              out_done_res
);

  logic [DIV_W-1:0]  div_r;
  logic              active_r,     active_nxt;
  logic [DIV_W-1:0]  tick_r,       tick_nxt;
  logic [BITS_W-1:0] bits_r,       bits_nxt;
  word_t             send_r,       send_nxt;
  word_t             recv_r,       recv_nxt;
  word_t             hold_r,       hold_nxt;
  logic              sclk_r,       sclk_nxt;
  logic              mosi_r,       mosi_nxt;
  logic              sel_n_r,      sel_n_nxt;
  logic              done_r,       done_nxt;

  logic              busy_before;
  logic [DIV_W-1:0]  div_eff;
  logic [DIV_W-1:0]  half_div;
  logic [DIV_W-1:0]  tick_inc;
  logic [BITS_W-1:0] bits_inc;
  word_t             tx_word;
  res_t              res_nxt;

  logic              in_acc;
  logic              out_acc;
  logic              out_v_r;
  logic              skid_v_r;
  res_t              out_data_r;
  res_t              skid_data_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign in_acc    = in_valid & ~skid_v_r;
  assign out_acc   = out_v_r & ~out_stall;

  assign div_eff  = (div_r < DIV_MIN) ? DIV_MIN : div_r;
  assign half_div = div_eff >> 1;
  assign tick_inc = tick_r + DIV_W'(1);
  assign bits_inc = bits_r + BITS_W'(1);
  assign tx_word  = WORD_BITS'(in_tx_byte);

  // one spi tick
  always_comb begin
    active_nxt  = active_r;
    tick_nxt    = tick_r;
    bits_nxt    = bits_r;
    send_nxt    = send_r;
    recv_nxt    = recv_r;
    hold_nxt    = hold_r;
    sclk_nxt    = sclk_r;
    mosi_nxt    = mosi_r;
    sel_n_nxt   = sel_n_r;
    done_nxt    = done_r;
    busy_before = active_r;
    if (in_soft_clear) begin
      active_nxt  = 1'b0;
      tick_nxt    = '0;
      bits_nxt    = '0;
      send_nxt    = '0;
      recv_nxt    = '0;
      hold_nxt    = '0;
      sclk_nxt    = 1'b0;
      mosi_nxt    = 1'b0;
      sel_n_nxt   = 1'b1;
      done_nxt    = 1'b0;
      busy_before = 1'b0;
    end else if (!active_r) begin
      done_nxt = 1'b0;
      sclk_nxt = 1'b0;
      if (in_start_req) begin
        active_nxt = 1'b1;
        bits_nxt   = '0;
        tick_nxt   = '0;
        recv_nxt   = '0;
        sel_n_nxt  = 1'b0;
        send_nxt   = tx_word << 1;
        mosi_nxt   = tx_word[WORD_BITS-1];
      end else begin
        sel_n_nxt = 1'b1;
        mosi_nxt  = 1'b0;
      end
    end else begin
      done_nxt = 1'b0;
      tick_nxt = tick_inc;
      if (tick_inc == half_div) begin
        sclk_nxt = 1'b1;
        recv_nxt = {recv_r[WORD_BITS-2:0], in_miso_bit};
      end else if (tick_inc >= div_eff) begin
        sclk_nxt = 1'b0;
        mosi_nxt = send_r[WORD_BITS-1];
        send_nxt = send_r << 1;
        tick_nxt = '0;
        bits_nxt = bits_inc;
        if (bits_inc >= BITS_W'(WORD_BITS)) begin
          sel_n_nxt  = 1'b1;
          mosi_nxt   = 1'b0;
          active_nxt = 1'b0;
          hold_nxt   = recv_r;
          done_nxt   = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_nxt.sclk     = sclk_nxt;
    res_nxt.mosi     = mosi_nxt;
    res_nxt.cs_n     = sel_n_nxt;
    res_nxt.rx_byte  = BYTE_W'(hold_nxt);
    res_nxt.busy_res = busy_before;
    res_nxt.done_res = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r    <= DIV_RESET;
      active_r <= 1'b0;
      tick_r   <= '0;
      bits_r   <= '0;
      send_r   <= '0;
      recv_r   <= '0;
      hold_r   <= '0;
      sclk_r   <= 1'b0;
      mosi_r   <= 1'b0;
      sel_n_r  <= 1'b1;
      done_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        div_r <= cfg_data;
      end
      if (in_acc) begin
        active_r <= active_nxt;
        tick_r   <= tick_nxt;
        bits_r   <= bits_nxt;
        send_r   <= send_nxt;
        recv_r   <= recv_nxt;
        hold_r   <= hold_nxt;
        sclk_r   <= sclk_nxt;
        mosi_r   <= mosi_nxt;
        sel_n_r  <= sel_n_nxt;
        done_r   <= done_nxt;
      end
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_acc || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc || !out_v_r) begin
      if (skid_v_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= res_nxt;
      end
    end else if (in_acc) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_sclk     = out_data_r.sclk;
  assign out_mosi     = out_data_r.mosi;
  assign out_cs_n     = out_data_r.cs_n;
  assign out_rx_byte  = out_data_r.rx_byte;
  assign out_busy_res = out_data_r.busy_res;
  assign out_done_res = out_data_r.done_res;

  a_sel_tracks_active: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == !sel_n_r)
    else $error("chip select out of step with transfer state");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!active_r && sel_n_r && !sclk_r))
    else $error("done raised while a transfer is running");

  a_idle_sclk_low: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> !sclk_r)
    else $error("sclk high while idle");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= BITS_W'(WORD_BITS))
    else $error("bit counter past word length");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry filled with output register empty");

endmodule

`default_nettype wire

/* bench/spibm_checker.sv */
`timescale 1ns / 1ps
// spibm_checker: tracks the spi engine tick by tick, predicts each result beat of
// spi_byte_master and compares it field by field with what the block delivers
// depends on spibm_pkg
module spibm_checker import spibm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [DIV_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic              in_start_req,
  input  wire logic [BYTE_W-1:0] in_tx_byte,
  input  wire logic              in_miso_bit,
  input  wire logic              in_soft_clear,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic              out_sclk,
  input  wire logic              out_mosi,
  input  wire logic              out_cs_n,
  input  wire logic [BYTE_W-1:0] out_rx_byte,
  input  wire logic              out_busy_res,
  input  wire logic              out_done_res,
  output int                     err_count,
  output int                     pending
);

  logic [DIV_W-1:0]  divider;
  logic              xfer_on;
  logic [DIV_W-1:0]  ticks;
  logic [BITS_W-1:0] nbits;
  word_t             tx_sr;
  word_t             rx_sr;
  word_t             rx_held;
  logic              sclk_q;
  logic              mosi_q;
  logic              csn_q;
  logic              done_q;
  res_t              due_results[$];
  int                errs;

  initial begin
    errs      = 0;
    err_count = 0;
    pending   = 0;
  end

  task automatic clear_engine();
    xfer_on = 1'b0;
    ticks   = '0;
    nbits   = '0;
    tx_sr   = '0;
    rx_sr   = '0;
    rx_held = '0;
    sclk_q  = 1'b0;
    mosi_q  = 1'b0;
    csn_q   = 1'b1;
    done_q  = 1'b0;
  endtask

  // one system tick of the spi engine
  task automatic spi_tick(input logic start, input logic [BYTE_W-1:0] tx,
                          input logic miso, input logic clr, output res_t r);
    logic [DIV_W-1:0] div;
    logic             was_busy;
    div      = (divider < DIV_MIN) ? DIV_MIN : divider;
    was_busy = xfer_on;
    if (clr) begin
      clear_engine();
      was_busy = 1'b0;
    end else if (!xfer_on) begin
      done_q = 1'b0;
      sclk_q = 1'b0;
      if (start) begin
        xfer_on = 1'b1;
        nbits   = '0;
        ticks   = '0;
        rx_sr   = '0;
        csn_q   = 1'b0;
        tx_sr   = word_t'(tx);
        mosi_q  = tx_sr[WORD_BITS-1];
        tx_sr   = tx_sr << 1;
      end else begin
        csn_q  = 1'b1;
        mosi_q = 1'b0;
      end
    end else begin
      done_q = 1'b0;
      ticks  = ticks + 1'b1;
      if (ticks == (div >> 1)) begin
        sclk_q = 1'b1;
        rx_sr  = (rx_sr << 1) | word_t'(miso);
      end else if (ticks >= div) begin
        sclk_q = 1'b0;
        mosi_q = tx_sr[WORD_BITS-1];
        tx_sr  = tx_sr << 1;
        ticks  = '0;
        nbits  = nbits + 1'b1;
        if (nbits >= WORD_BITS) begin
          csn_q   = 1'b1;
          mosi_q  = 1'b0;
          xfer_on = 1'b0;
          rx_held = rx_sr;
          done_q  = 1'b1;
        end
      end
    end
    r.sclk     = sclk_q;
    r.mosi     = mosi_q;
    r.cs_n     = csn_q;
    r.rx_byte  = BYTE_W'(rx_held);
    r.busy_res = was_busy;
    r.done_res = done_q;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      divider = DIV_RESET;
      clear_engine();
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errs++;
          $display("%0t: result beat expected none actual %b%b%b %h %b%b", $time,
                   out_sclk, out_mosi, out_cs_n, out_rx_byte, out_busy_res, out_done_res);
        end else begin
          want = due_results.pop_front();
          check_field("sclk", want.sclk, out_sclk);
          check_field("mosi", want.mosi, out_mosi);
          check_field("cs_n", want.cs_n, out_cs_n);
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("busy_res", want.busy_res, out_busy_res);
          check_field("done_res", want.done_res, out_done_res);
        end
      end
      if (cfg_valid && cfg_ready)
        divider = cfg_data;
      if (in_valid && !in_stall) begin
        spi_tick(in_start_req, in_tx_byte, in_miso_bit, in_soft_clear, want);
        due_results.push_back(want);
      end
    end
    pending   <= due_results.size();
    err_count <= errs;
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench: drives directed and random tick beats and divider settings into
// spi_byte_master, with the checker alongside; depends on spibm_pkg and spibm_checker
module testbench;
  import spibm_pkg::*;

  localparam int QUIET_LIMIT = 3000;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [DIV_W-1:0]  cfg_data      = '0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic              in_start_req  = 1'b0;
  logic [BYTE_W-1:0] in_tx_byte    = '0;
  logic              in_miso_bit   = 1'b0;
  logic              in_soft_clear = 1'b0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic              out_sclk;
  logic              out_mosi;
  logic              out_cs_n;
  logic [BYTE_W-1:0] out_rx_byte;
  logic              out_busy_res;
  logic              out_done_res;
  int                err_count;
  int                pending;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int hold_req     = 0;
  int hold_left    = 0;
  int quiet        = 0;

  spi_byte_master u_dut (.*);

  spibm_checker u_checker (.*);

  always #4 clk = ~clk;

  // receiver side: random stalls plus long hold-offs on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic put_tick(input logic start, input logic [BYTE_W-1:0] tx,
                          input logic miso, input logic clr);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_tx_byte    <= tx;
    in_miso_bit   <= miso;
    in_soft_clear <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_divider(input logic [DIV_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic feed_random(input int n);
    repeat (n)
      put_tick($urandom_range(0, 99) < 30, BYTE_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), $urandom_range(0, 99) == 0);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct  = 7;
    out_idle_pct = 47;

    // whole transfer at the fastest divider, start held high while busy
    set_divider(DIV_W'(2));
    put_tick(1'b0, 8'hFF, 1'b1, 1'b0);
    put_tick(1'b1, 8'hA5, 1'b0, 1'b0);
    for (int k = 0; k < 16; k++)
      put_tick(1'b1, 8'(k * 37), k[0] ^ k[2], 1'b0);

    // soft clear in the middle of a transfer
    put_tick(1'b1, 8'hFF, 1'b1, 1'b0);
    put_tick(1'b0, 8'h00, 1'b1, 1'b0);
    put_tick(1'b1, 8'h7F, 1'b1, 1'b1);

    // divider shrinks below the running count
    set_divider(DIV_W'(10));
    put_tick(1'b1, 8'h01, 1'b1, 1'b0);
    repeat (4) put_tick(1'b0, 8'h00, 1'b1, 1'b0);
    set_divider(DIV_W'(2));
    put_tick(1'b0, 8'h00, 1'b0, 1'b0);

    set_divider(DIV_W'(5));
    feed_random(120);
    set_divider(DIV_W'(1));
    feed_random(80);

    in_idle_pct  = 47;
    out_idle_pct = 7;
    set_divider(DIV_W'(3));
    feed_random(120);
    set_divider(DIV_W'(7));
    feed_random(80);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_divider(DIV_W'(4));
    hold_req = 60;
    feed_random(100);
    set_divider(DIV_W'(65535));
    feed_random(40);
    set_divider(DIV_W'(0));
    feed_random(30);

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

/* sim.f */
src/spibm_pkg.sv
src/spi_byte_master.sv
bench/spibm_checker.sv
bench/testbench.sv
